/* rtl/ssp_pkg.sv */
`default_nettype none

package ssp_pkg;

   // defaults for the top-level parameters
   localparam int MAX_ROWS_DEF      = 1024;
   localparam int FRACTION_BITS_DEF = 16;

   // fixed field widths
   localparam int KIND_W      = 3;
   localparam int PY_W        = 16;
   localparam int ROW_IDX_W   = 16;
   localparam int CNT_IN_W    = 11;
   localparam int OUT_POS_W   = 26;
   localparam int OUT_ROW_W   = 10;
   localparam int OUT_CNT_W   = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int DSR_W       = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EASE_DIVISOR     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_HEIGHT       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERACTIVE_MODE = 2'd2;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] EASE_DIVISOR_RST = 8'd4;
   localparam logic [CSR_DATA_W-1:0] ROW_HEIGHT_RST   = 8'd24;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK      = 3'd0,
      KIND_PRESS     = 3'd1,
      KIND_DRAG      = 3'd2,
      KIND_RELEASE   = 3'd3,
      KIND_SELECT    = 3'd4,
      KIND_SET_COUNT = 3'd5,
      KIND_ADD_LINE  = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } seq_state_type;

endpackage

`default_nettype wire

/* rtl/ssp_div.sv */
`default_nettype none

// restoring divider, one quotient bit per cycle
module ssp_div #(
   parameter int DVD_W = 32,
   parameter int DSR_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DSR_W-1:0] divisor,
   output logic                  done,
   output logic      [DVD_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DSR_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CNT_W'(DVD_W);
      end else if (cnt_ff != '0) begin
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? DSR_W'(trial - {1'b0, dsr_ff}) : trial[DSR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* rtl/smooth_scroll_position_tracker.sv */
`default_nettype none

// Smooth scroll position tracker. Holds a fixed-point scroll position
// (FRACTION_BITS fraction bits), a target row and a row count. A tick eases
// the position toward the target row by diff/ease_divisor (1/256 row if
// that quotient is zero, never past the goal); press/drag/release let a
// pointer move the position in interactive mode, and release snaps the
// target to the nearest row. Select, set count and add line manage target
// and count. Every request transfer yields exactly one response transfer.
// Timing: one item at a time; req_ready is high only while the sequencer
// idles. A tick that has to ease, or a drag in interactive mode, runs the
// shared bit-serial divider: its request passes through ST_DIV and then
// ST_DONE before the response is loaded, while other kinds go straight to
// ST_DONE. The response is loaded as the sequencer leaves ST_DONE for
// ST_IDLE. A response still held by rsp_ready low delays the load of the
// next one, and so the return to idle. A new request may be taken while
// the previous response still waits. The divider retires one quotient bit
// per cycle.
// Configuration writes are taken any time but are meant for idle periods.
module smooth_scroll_position_tracker #(
   parameter int MAX_ROWS      = ssp_pkg::MAX_ROWS_DEF,
   parameter int FRACTION_BITS = ssp_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [ssp_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [ssp_pkg::PY_W-1:0]       req_pointer_y,
   input  wire logic                           req_pressed_now,
   input  wire logic [ssp_pkg::ROW_IDX_W-1:0]  req_row_index,
   input  wire logic                           req_animate,
   input  wire logic [ssp_pkg::CNT_IN_W-1:0]   req_new_count,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [ssp_pkg::OUT_POS_W-1:0]  rsp_position,
   output logic      [ssp_pkg::OUT_ROW_W-1:0]  rsp_selected_row,
   output logic      [ssp_pkg::OUT_CNT_W-1:0]  rsp_row_count,
   output logic                                rsp_changed,
   output logic                                rsp_moving,
   // configuration
   input  wire logic                           csr_we,
   input  wire logic [ssp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ssp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ssp_pkg::*;

   localparam int FB    = FRACTION_BITS;
   localparam int TGT_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CNT_W = $clog2(MAX_ROWS + 1);
   localparam int POS_W = TGT_W + FB;
   // divider takes either a position difference or |pixels| << FB
   localparam int DVD_W = (POS_W > PY_W + FB) ? POS_W : PY_W + FB;
   localparam int SW    = DVD_W + 2;
   localparam int RW    = (TGT_W + 1 > CNT_W) ? TGT_W + 1 : CNT_W;
   localparam int CW    = (ROW_IDX_W - 1 > CNT_W) ? ROW_IDX_W - 1 : CNT_W;
   localparam int NCW   = (CNT_IN_W > CNT_W) ? CNT_IN_W : CNT_W;
   localparam logic [DVD_W-1:0] MIN_STEP = DVD_W'(1) << (FB - 8);
   localparam logic [POS_W:0]   HALF_ROW = (POS_W + 1)'(1) << (FB - 1);

   // configuration registers
   logic [CSR_DATA_W-1:0] ease_div_ff, ease_div_in;
   logic [CSR_DATA_W-1:0] row_height_ff, row_height_in;
   logic                  inter_ff, inter_in;

   always_comb begin
      ease_div_in   = ease_div_ff;
      row_height_in = row_height_ff;
      inter_in      = inter_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_EASE_DIVISOR:     ease_div_in   = csr_wdata;
            CSR_ROW_HEIGHT:       row_height_in = csr_wdata;
            CSR_INTERACTIVE_MODE: inter_in      = csr_wdata[0];
            default: ;  // unmapped index: dropped
         endcase
      end
   end

   // tracker state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [TGT_W-1:0] target_ff, target_in;
   logic [CNT_W-1:0] rows_ff, rows_in;
   logic [PY_W-1:0]  anchor_y_ff, anchor_y_in;
   logic [POS_W-1:0] anchor_pos_ff, anchor_pos_in;

   // captured request
   logic [KIND_W-1:0]    kind_ff;
   logic [PY_W-1:0]      py_ff;
   logic                 held_ff;
   logic [ROW_IDX_W-1:0] row_idx_ff;
   logic                 animate_ff;
   logic [CNT_IN_W-1:0]  new_count_ff;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_POS_W-1:0] rsp_position_ff;
   logic [OUT_ROW_W-1:0] rsp_row_ff;
   logic [OUT_CNT_W-1:0] rsp_count_ff;
   logic                 rsp_changed_ff;
   logic                 rsp_moving_ff;

   seq_state_type state_ff, state_in;

   logic             accept, commit, need_div, div_start, div_done;
   logic [DVD_W-1:0] dividend, quotient;
   logic [DSR_W-1:0] divisor;

   // shared terms
   logic [CNT_W-1:0] rows_m1;
   logic [POS_W-1:0] goal, hi, diff_mag;
   logic             diff_neg, ease_jump;
   logic [DSR_W-1:0] rh_eff;

   assign rows_m1   = rows_ff - 1'b1;
   assign goal      = {target_ff, {FB{1'b0}}};
   assign hi        = (rows_ff == '0) ? '0 : {rows_m1[TGT_W-1:0], {FB{1'b0}}};
   assign diff_neg  = goal < pos_ff;
   assign diff_mag  = diff_neg ? pos_ff - goal : goal - pos_ff;
   assign ease_jump = ease_div_ff <= DSR_W'(1);
   assign rh_eff    = (row_height_ff == '0) ? DSR_W'(1) : row_height_ff;

   // divider operands, taken straight from the request at its transfer
   logic [PY_W:0]   req_delta, req_delta_mag;

   assign req_delta     = {anchor_y_ff[PY_W-1], anchor_y_ff}
                        - {req_pointer_y[PY_W-1], req_pointer_y};
   assign req_delta_mag = req_delta[PY_W] ? -req_delta : req_delta;

   always_comb begin
      need_div = 1'b0;
      dividend = DVD_W'(diff_mag);
      divisor  = ease_div_ff;
      if (req_kind == KIND_TICK) begin
         need_div = !(inter_ff && req_pressed_now) && (diff_mag != '0) && !ease_jump;
      end else if (req_kind == KIND_DRAG) begin
         need_div = inter_ff;
         dividend = DVD_W'({req_delta_mag[PY_W-1:0], {FB{1'b0}}});
         divisor  = rh_eff;
      end
   end

   ssp_div #(
      .DVD_W (DVD_W),
      .DSR_W (DSR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = need_div ? ST_DIV : ST_DONE;
         ST_DIV:  if (div_done) state_in = ST_DONE;
         ST_DONE: if (commit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && req_ready;
      div_start = accept && need_div;
      commit    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   // tick: step magnitude, the minimum step when the quotient is zero
   logic [DVD_W-1:0] step_mag;
   logic [POS_W-1:0] tick_pos;
   logic             step_reaches;

   assign step_mag     = (quotient == '0) ? MIN_STEP : quotient;
   assign step_reaches = step_mag >= DVD_W'(diff_mag);
   assign tick_pos     = diff_neg ? pos_ff - POS_W'(step_mag) : pos_ff + POS_W'(step_mag);

   // drag: anchor +/- rows moved, clamped to [0, hi]
   logic [PY_W:0]    drag_delta;
   logic [SW-1:0]    drag_sum;
   logic [POS_W-1:0] drag_pos;

   assign drag_delta = {anchor_y_ff[PY_W-1], anchor_y_ff} - {py_ff[PY_W-1], py_ff};
   assign drag_sum   = drag_delta[PY_W]
                     ? {2'b00, DVD_W'(anchor_pos_ff)} - {2'b00, quotient}
                     : {2'b00, DVD_W'(anchor_pos_ff)} + {2'b00, quotient};

   always_comb begin
      if (drag_sum[SW-1])
         drag_pos = '0;
      else if (drag_sum[SW-2:0] > (SW-1)'(hi))
         drag_pos = hi;
      else
         drag_pos = POS_W'(drag_sum);
   end

   // release: round to nearest row, clamp
   logic [POS_W:0]   rel_sum;
   logic [TGT_W:0]   rel_near;
   logic [TGT_W-1:0] rel_target;

   assign rel_sum  = {1'b0, pos_ff} + HALF_ROW;
   assign rel_near = rel_sum[POS_W:FB];

   always_comb begin
      if (rows_ff == '0)
         rel_target = '0;
      else if (RW'(rel_near) > RW'(rows_m1))
         rel_target = TGT_W'(rows_m1);
      else
         rel_target = TGT_W'(rel_near);
   end

   // select: clamp signed index into the list
   logic [TGT_W-1:0] sel_target;

   always_comb begin
      if (rows_ff == '0 || row_idx_ff[ROW_IDX_W-1])
         sel_target = '0;
      else if (CW'(row_idx_ff[ROW_IDX_W-2:0]) > CW'(rows_m1))
         sel_target = TGT_W'(rows_m1);
      else
         sel_target = TGT_W'(row_idx_ff[ROW_IDX_W-2:0]);
   end

   // set count: saturate, then pull the target inside
   logic [CNT_W-1:0] set_rows, set_m1;
   logic [TGT_W-1:0] set_target;

   assign set_rows = (NCW'(new_count_ff) > NCW'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
                                                           : CNT_W'(new_count_ff);
   assign set_m1   = set_rows - 1'b1;

   always_comb begin
      if (set_rows == '0)
         set_target = '0;
      else if (CNT_W'(target_ff) > set_m1)
         set_target = TGT_W'(set_m1);
      else
         set_target = target_ff;
   end

   // item outcome
   logic changed, moving;

   always_comb begin
      pos_in        = pos_ff;
      target_in     = target_ff;
      rows_in       = rows_ff;
      anchor_y_in   = anchor_y_ff;
      anchor_pos_in = anchor_pos_ff;
      changed       = 1'b0;
      moving        = 1'b0;
      case (kind_ff)
         KIND_TICK: begin
            if (inter_ff && held_ff) begin
               moving = 1'b1;
            end else if (diff_mag != '0) begin
               if (ease_jump || step_reaches) begin
                  pos_in = goal;
               end else begin
                  pos_in = tick_pos;
                  moving = 1'b1;
               end
            end
         end
         KIND_PRESS: begin
            if (inter_ff) begin
               anchor_y_in   = py_ff;
               anchor_pos_in = pos_ff;
            end
         end
         KIND_DRAG: begin
            if (inter_ff) pos_in = drag_pos;
         end
         KIND_RELEASE: begin
            if (inter_ff) begin
               target_in = rel_target;
               changed   = rel_target != target_ff;
            end
         end
         KIND_SELECT: begin
            target_in = sel_target;
            changed   = sel_target != target_ff;
            if (!animate_ff || ease_jump) pos_in = {sel_target, {FB{1'b0}}};
         end
         KIND_SET_COUNT: begin
            rows_in   = set_rows;
            target_in = set_target;
            pos_in    = {set_target, {FB{1'b0}}};
         end
         KIND_ADD_LINE: begin
            if (rows_ff < CNT_W'(MAX_ROWS)) rows_in = rows_ff + 1'b1;
         end
         default: ;  // unused kind: no effect
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         ease_div_ff   <= EASE_DIVISOR_RST;
         row_height_ff <= ROW_HEIGHT_RST;
         inter_ff      <= 1'b0;
         pos_ff        <= '0;
         target_ff     <= '0;
         rows_ff       <= '0;
         anchor_y_ff   <= '0;
         anchor_pos_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         ease_div_ff   <= ease_div_in;
         row_height_ff <= row_height_in;
         inter_ff      <= inter_in;
         if (commit) begin
            pos_ff        <= pos_in;
            target_ff     <= target_in;
            rows_ff       <= rows_in;
            anchor_y_ff   <= anchor_y_in;
            anchor_pos_ff <= anchor_pos_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff      <= req_kind;
         py_ff        <= req_pointer_y;
         held_ff      <= req_pressed_now;
         row_idx_ff   <= req_row_index;
         animate_ff   <= req_animate;
         new_count_ff <= req_new_count;
      end
      if (commit) begin
         rsp_position_ff <= OUT_POS_W'(pos_in);
         rsp_row_ff      <= OUT_ROW_W'(target_in);
         rsp_count_ff    <= OUT_CNT_W'(rows_in);
         rsp_changed_ff  <= changed;
         rsp_moving_ff   <= moving;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_selected_row = rsp_row_ff;
   assign rsp_row_count    = rsp_count_ff;
   assign rsp_changed      = rsp_changed_ff;
   assign rsp_moving       = rsp_moving_ff;

endmodule

`default_nettype wire
